### design/lens_distortion_point_map_core_macros.svh
// Assertion macros shared by the lens distortion point map design.
`ifndef LENS_DISTORTION_POINT_MAP_CORE_MACROS_SVH
`define LENS_DISTORTION_POINT_MAP_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define LDPM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ldpm: same-cycle check failed");

`define LDPM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ldpm: next-cycle check failed");

`else

`define LDPM_ASSERT_IMP(lbl, ante, cons)

`define LDPM_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### design/ldpm_pkg.sv
// Shared types, constants and fixed-point helpers of the lens distortion point map.
package ldpm_pkg;

	localparam int FRAC_BITS = 24;
	localparam int MAX_DIM   = 4096;
	localparam int SRC_W     = 12;
	localparam int DIM_W     = 13;
	localparam int DEST_W    = 13;
	localparam int COLOR_W   = 8;
	localparam int REG_W     = 32;
	localparam int SIZE_W    = 26;
	localparam int ADDR_W    = 5;
	localparam int DIV_STEPS = SRC_W + FRAC_BITS;
	localparam int PROD_W    = REG_W + 1 + DIM_W;
	localparam int DX_W      = PROD_W - FRAC_BITS;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8193);
	localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;
	localparam logic signed [63:0] ONE64  = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [REG_W-1:0] NEG_ONE = -(32'sd1 <<< FRAC_BITS);

	typedef enum logic [2:0] {
		REG_K1   = 3'd0,
		REG_K2   = 3'd1,
		REG_K3   = 3'd2,
		REG_P1   = 3'd3,
		REG_P2   = 3'd4,
		REG_CX   = 3'd5,
		REG_CY   = 3'd6,
		REG_SIZE = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] alpha;
	} pix_t;

	typedef struct packed {
		pix_t             pix;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} side_t;

	typedef struct packed {
		logic [SRC_W-1:0] sx;
		logic [SRC_W-1:0] sy;
		side_t            side;
	} item_t;

	typedef struct packed {
		logic [DEST_W-1:0] dx;
		logic [DEST_W-1:0] dy;
		pix_t              pix;
	} res_t;

	typedef struct packed {
		logic signed [REG_W-1:0] k1;
		logic signed [REG_W-1:0] k2;
		logic signed [REG_W-1:0] k3;
		logic signed [REG_W-1:0] p1;
		logic signed [REG_W-1:0] p2;
		logic signed [REG_W-1:0] cx;
		logic signed [REG_W-1:0] cy;
	} coef_t;

	typedef struct packed {
		logic       adv;
		logic       res_push;
		logic [1:0] res_cnt;
	} back_stat_t;

	function automatic logic signed [63:0] sext64(input logic signed [REG_W-1:0] a);
		return $signed({{(64-REG_W){a[REG_W-1]}}, a});
	endfunction

	function automatic logic signed [REG_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [REG_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[REG_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[REG_W-1:0];
		end else begin
			r = v[REG_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [REG_W-1:0] fmul(input logic signed [REG_W-1:0] a,
			input logic signed [REG_W-1:0] b);
		logic signed [63:0] p;
		p = sext64(a) * sext64(b);
		return sat32(p >>> FRAC_BITS);
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		if (d == '0) begin
			r = DIM_W'(1);
		end else if (d > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = d;
		end
		return r;
	endfunction

endpackage

### design/ldpm_front.sv
// Input side: takes requests, clamps the image size and buffers them in a short queue.
module ldpm_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [ldpm_pkg::SRC_W-1:0]     src_x,
	input  logic [ldpm_pkg::SRC_W-1:0]     src_y,
	input  ldpm_pkg::pix_t                 pix,
	input  logic [ldpm_pkg::SIZE_W-1:0]    size,
	input  logic                           adv,
	output logic                           take,
	output ldpm_pkg::item_t                head
);
	import ldpm_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	item_t              mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     cnt_q;
	logic               acc;
	item_t              entry;

	assign full = (cnt_q == (PTR_W+1)'(DEPTH));
	assign acc  = push && !full;
	assign take = adv && (cnt_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_comb begin
		entry.sx        = src_x;
		entry.sy        = src_y;
		entry.side.pix  = pix;
		entry.side.w    = clamp_dim(size[DIM_W-1:0]);
		entry.side.h    = clamp_dim(size[SIZE_W-1:DIM_W]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (acc) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (acc && !take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!acc && take) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

endmodule

### design/ldpm_div.sv
// Pipelined restoring divider that normalizes both coordinates by the image size.
module ldpm_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             in_valid,
	input  ldpm_pkg::item_t                  in_item,
	output logic                             out_valid,
	output ldpm_pkg::side_t                  out_side,
	output logic [ldpm_pkg::DIV_STEPS-1:0]   out_qx,
	output logic [ldpm_pkg::DIV_STEPS-1:0]   out_qy
);
	import ldpm_pkg::*;

	logic                 vld   [DIV_STEPS+1];
	item_t                item  [DIV_STEPS+1];
	logic [DIM_W-1:0]     rem_x [DIV_STEPS+1];
	logic [DIM_W-1:0]     rem_y [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] quo_x [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] quo_y [DIV_STEPS+1];

	assign vld[0]   = in_valid;
	assign item[0]  = in_item;
	assign rem_x[0] = '0;
	assign rem_y[0] = '0;
	assign quo_x[0] = '0;
	assign quo_y[0] = '0;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic             nbx;
		logic             nby;
		logic [DIM_W-1:0] shx;
		logic [DIM_W-1:0] shy;
		logic             gex;
		logic             gey;

		if (i < SRC_W) begin : g_num
			assign nbx = item[i].sx[SRC_W-1-i];
			assign nby = item[i].sy[SRC_W-1-i];
		end else begin : g_pad
			assign nbx = 1'b0;
			assign nby = 1'b0;
		end

		assign shx = {rem_x[i][DIM_W-2:0], nbx};
		assign shy = {rem_y[i][DIM_W-2:0], nby};
		assign gex = (shx >= item[i].side.w);
		assign gey = (shy >= item[i].side.h);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i+1] <= 1'b0;
			end else if (adv) begin
				vld[i+1] <= vld[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				item[i+1]  <= item[i];
				rem_x[i+1] <= gex ? (shx - item[i].side.w) : shx;
				rem_y[i+1] <= gey ? (shy - item[i].side.h) : shy;
				quo_x[i+1] <= {quo_x[i][DIV_STEPS-2:0], gex};
				quo_y[i+1] <= {quo_y[i][DIV_STEPS-2:0], gey};
			end
		end
	end

	assign out_valid = vld[DIV_STEPS];
	assign out_side  = item[DIV_STEPS].side;
	assign out_qx    = quo_x[DIV_STEPS];
	assign out_qy    = quo_y[DIV_STEPS];

endmodule

### design/ldpm_back.sv
// Distortion pipeline, destination scaling, range check and result queue.
module ldpm_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  ldpm_pkg::side_t                  in_side,
	input  logic [ldpm_pkg::DIV_STEPS-1:0]   in_qx,
	input  logic [ldpm_pkg::DIV_STEPS-1:0]   in_qy,
	input  ldpm_pkg::coef_t                  coef,
	output logic                             empty,
	input  logic                             pop,
	output ldpm_pkg::res_t                   res,
	output ldpm_pkg::back_stat_t             stat
);
	import ldpm_pkg::*;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	side_t sd_s1, sd_s2, sd_s3, sd_s4, sd_s5, sd_s6, sd_s7, sd_s8, sd_s9, sd_s10, sd_s11;

	logic signed [REG_W-1:0] xn, yn;
	logic signed [REG_W-1:0] xp_s1, yp_s1, xp_s2, yp_s2, xp_s3, yp_s3, xp_s4, yp_s4;
	logic signed [REG_W-1:0] xp_s5, yp_s5, xp_s6, yp_s6, xp_s7, yp_s7;
	logic signed [REG_W-1:0] xx_s2, yy_s2, xy_s2, xx_s3, yy_s3, xy_s3;
	logic signed [REG_W-1:0] r2_s3, r2_s4, r2_s5;
	logic signed [REG_W-1:0] r4_s4, qx_s4, qy_s4, p1xy_s4, p2xy_s4, r2k1_s4;
	logic signed [REG_W-1:0] r6_s5, r4k2_s5, txb_s5, tya_s5, p1xy_s5, p2xy_s5, r2k1_s5;
	logic signed [REG_W-1:0] r6k3_s6, tx_s6, ty_s6, tx_s7, ty_s7, tx_s8, ty_s8;
	logic signed [63:0]      rcp_s6;
	logic signed [REG_W-1:0] rc_s7, mx_s8, my_s8, xc_s9, yc_s9;
	logic signed [63:0]      ux_sum, uy_sum;
	logic [REG_W:0]          ux_s10, uy_s10;
	logic                    neg_s10, neg_s11;
	logic [PROD_W-1:0]       px, py;
	logic [DX_W-1:0]         dx_s11, dy_s11;
	logic                    ok;

	res_t       rq_q [2];
	logic       rq_wr_q;
	logic       rq_rd_q;
	logic [1:0] rq_cnt_q;
	logic       res_push;
	logic       res_pop;
	res_t       res_new;

	assign adv = (rq_cnt_q != 2'd2);

	assign xn = (|in_qx[DIV_STEPS-1:REG_W-1]) ? SAT_HI[REG_W-1:0] : $signed({1'b0, in_qx[REG_W-2:0]});
	assign yn = (|in_qy[DIV_STEPS-1:REG_W-1]) ? SAT_HI[REG_W-1:0] : $signed({1'b0, in_qy[REG_W-2:0]});

	assign ux_sum = sext64(xc_s9) + ONE64;
	assign uy_sum = sext64(yc_s9) + ONE64;
	assign px     = PROD_W'(ux_s10) * PROD_W'(sd_s10.w);
	assign py     = PROD_W'(uy_s10) * PROD_W'(sd_s10.h);
	assign ok     = !neg_s11 && (dx_s11 < DX_W'({sd_s11.w, 1'b0}))
		&& (dy_s11 < DX_W'({sd_s11.h, 1'b0}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11} <= '0;
		end else if (adv) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11}
				<= {in_valid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s1  <= in_side;
			sd_s2  <= sd_s1;
			sd_s3  <= sd_s2;
			sd_s4  <= sd_s3;
			sd_s5  <= sd_s4;
			sd_s6  <= sd_s5;
			sd_s7  <= sd_s6;
			sd_s8  <= sd_s7;
			sd_s9  <= sd_s8;
			sd_s10 <= sd_s9;
			sd_s11 <= sd_s10;

			xp_s1 <= sat32(sext64(xn) - sext64(coef.cx));
			yp_s1 <= sat32(sext64(yn) - sext64(coef.cy));

			xx_s2 <= fmul(xp_s1, xp_s1);
			yy_s2 <= fmul(yp_s1, yp_s1);
			xy_s2 <= fmul(xp_s1, yp_s1);
			xp_s2 <= xp_s1;
			yp_s2 <= yp_s1;

			r2_s3 <= sat32(sext64(xx_s2) + sext64(yy_s2));
			xx_s3 <= xx_s2;
			yy_s3 <= yy_s2;
			xy_s3 <= xy_s2;
			xp_s3 <= xp_s2;
			yp_s3 <= yp_s2;

			r4_s4   <= fmul(r2_s3, r2_s3);
			qx_s4   <= sat32(sext64(r2_s3) + (sext64(xx_s3) <<< 1));
			qy_s4   <= sat32(sext64(r2_s3) + (sext64(yy_s3) <<< 1));
			p1xy_s4 <= fmul(coef.p1, xy_s3);
			p2xy_s4 <= fmul(coef.p2, xy_s3);
			r2k1_s4 <= fmul(r2_s3, coef.k1);
			r2_s4   <= r2_s3;
			xp_s4   <= xp_s3;
			yp_s4   <= yp_s3;

			r6_s5   <= fmul(r4_s4, r2_s4);
			r4k2_s5 <= fmul(r4_s4, coef.k2);
			txb_s5  <= fmul(coef.p2, qx_s4);
			tya_s5  <= fmul(coef.p1, qy_s4);
			p1xy_s5 <= p1xy_s4;
			p2xy_s5 <= p2xy_s4;
			r2k1_s5 <= r2k1_s4;
			r2_s5   <= r2_s4;
			xp_s5   <= xp_s4;
			yp_s5   <= yp_s4;

			r6k3_s6 <= fmul(r6_s5, coef.k3);
			tx_s6   <= sat32(sext64(sat32(sext64(p1xy_s5) <<< 1)) + sext64(txb_s5));
			ty_s6   <= sat32(sext64(tya_s5) + sext64(sat32(sext64(p2xy_s5) <<< 1)));
			rcp_s6  <= ONE64 + sext64(r2k1_s5) + sext64(r4k2_s5);
			xp_s6   <= xp_s5;
			yp_s6   <= yp_s5;

			rc_s7 <= sat32(rcp_s6 + sext64(r6k3_s6));
			tx_s7 <= tx_s6;
			ty_s7 <= ty_s6;
			xp_s7 <= xp_s6;
			yp_s7 <= yp_s6;

			mx_s8 <= fmul(xp_s7, rc_s7);
			my_s8 <= fmul(yp_s7, rc_s7);
			tx_s8 <= tx_s7;
			ty_s8 <= ty_s7;

			xc_s9 <= sat32(sext64(mx_s8) + sext64(tx_s8));
			yc_s9 <= sat32(sext64(my_s8) + sext64(ty_s8));

			neg_s10 <= (xc_s9 < NEG_ONE) || (yc_s9 < NEG_ONE);
			ux_s10  <= ux_sum[REG_W:0];
			uy_s10  <= uy_sum[REG_W:0];

			neg_s11 <= neg_s10;
			dx_s11  <= px[PROD_W-1:FRAC_BITS];
			dy_s11  <= py[PROD_W-1:FRAC_BITS];
		end
	end

	assign res_push    = adv && v_s11 && ok;
	assign res_pop     = pop && (rq_cnt_q != 2'd0);
	assign res_new.dx  = dx_s11[DEST_W-1:0];
	assign res_new.dy  = dy_s11[DEST_W-1:0];
	assign res_new.pix = sd_s11.pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= 1'b0;
			rq_rd_q  <= 1'b0;
			rq_cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				rq_wr_q <= !rq_wr_q;
			end
			if (res_pop) begin
				rq_rd_q <= !rq_rd_q;
			end
			if (res_push && !res_pop) begin
				rq_cnt_q <= rq_cnt_q + 2'd1;
			end else if (!res_push && res_pop) begin
				rq_cnt_q <= rq_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			rq_q[rq_wr_q] <= res_new;
		end
	end

	assign empty         = (rq_cnt_q == 2'd0);
	assign res           = rq_q[rq_rd_q];
	assign stat.adv      = adv;
	assign stat.res_push = res_push;
	assign stat.res_cnt  = rq_cnt_q;

endmodule

### design/lens_distortion_point_map_core.sv
// Top level of the lens distortion point map: register file, front queue, divider and back end.
//
// Channel   Handshake            Moves
// input     push / full          one source pixel request (coordinates and color)
// result    pop / empty          one destination pixel request, none for rejected points
// config    psel/penable/pwrite  coefficient, center and image size registers
//
// One request enters per clock while the front queue is not full; each taken request passes
// through the 36-step divider and the 11 stages of the distortion datapath to the result queue.
// A rejected point leaves no result and takes no slot in the result queue.
// When the two-entry result queue is full the datapath holds; the front queue keeps taking
// requests until its four entries are used. Reset needs no clearing pass.
module lens_distortion_point_map_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [ldpm_pkg::SRC_W-1:0]       src_x,
	input  logic [ldpm_pkg::SRC_W-1:0]       src_y,
	input  logic [ldpm_pkg::COLOR_W-1:0]     in_red,
	input  logic [ldpm_pkg::COLOR_W-1:0]     in_green,
	input  logic [ldpm_pkg::COLOR_W-1:0]     in_blue,
	input  logic [ldpm_pkg::COLOR_W-1:0]     in_alpha,
	output logic                             empty,
	input  logic                             pop,
	output logic [ldpm_pkg::DEST_W-1:0]      dest_x,
	output logic [ldpm_pkg::DEST_W-1:0]      dest_y,
	output logic [ldpm_pkg::COLOR_W-1:0]     out_red,
	output logic [ldpm_pkg::COLOR_W-1:0]     out_green,
	output logic [ldpm_pkg::COLOR_W-1:0]     out_blue,
	output logic [ldpm_pkg::COLOR_W-1:0]     out_alpha,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ldpm_pkg::ADDR_W-1:0]      paddr,
	input  logic [ldpm_pkg::REG_W-1:0]       pwdata,
	output logic [ldpm_pkg::REG_W-1:0]       prdata,
	output logic                             pready
);
	import ldpm_pkg::*;

	`include "lens_distortion_point_map_core_macros.svh"

	coef_t                coef_q;
	logic [SIZE_W-1:0]    size_q;
	reg_idx_t             idx;
	logic                 wr;
	pix_t                 in_pix;
	logic                 take;
	item_t                head;
	logic                 d_valid;
	side_t                d_side;
	logic [DIV_STEPS-1:0] d_qx;
	logic [DIV_STEPS-1:0] d_qy;
	res_t                 res;
	back_stat_t           bstat;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			size_q <= SIZE_RESET;
		end else if (wr) begin
			unique case (idx)
				REG_K1:   coef_q.k1 <= pwdata;
				REG_K2:   coef_q.k2 <= pwdata;
				REG_K3:   coef_q.k3 <= pwdata;
				REG_P1:   coef_q.p1 <= pwdata;
				REG_P2:   coef_q.p2 <= pwdata;
				REG_CX:   coef_q.cx <= pwdata;
				REG_CY:   coef_q.cy <= pwdata;
				REG_SIZE: size_q    <= pwdata[SIZE_W-1:0];
				default:  size_q    <= size_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_K1:   prdata = coef_q.k1;
			REG_K2:   prdata = coef_q.k2;
			REG_K3:   prdata = coef_q.k3;
			REG_P1:   prdata = coef_q.p1;
			REG_P2:   prdata = coef_q.p2;
			REG_CX:   prdata = coef_q.cx;
			REG_CY:   prdata = coef_q.cy;
			REG_SIZE: prdata = REG_W'(size_q);
			default:  prdata = '0;
		endcase
	end

	assign in_pix.red   = in_red;
	assign in_pix.green = in_green;
	assign in_pix.blue  = in_blue;
	assign in_pix.alpha = in_alpha;

	ldpm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.src_x  (src_x),
		.src_y  (src_y),
		.pix    (in_pix),
		.size   (size_q),
		.adv    (bstat.adv),
		.take   (take),
		.head   (head)
	);

	ldpm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (bstat.adv),
		.in_valid  (take),
		.in_item   (head),
		.out_valid (d_valid),
		.out_side  (d_side),
		.out_qx    (d_qx),
		.out_qy    (d_qy)
	);

	ldpm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (d_valid),
		.in_side  (d_side),
		.in_qx    (d_qx),
		.in_qy    (d_qy),
		.coef     (coef_q),
		.empty    (empty),
		.pop      (pop),
		.res      (res),
		.stat     (bstat)
	);

	assign dest_x    = res.dx;
	assign dest_y    = res.dy;
	assign out_red   = res.pix.red;
	assign out_green = res.pix.green;
	assign out_blue  = res.pix.blue;
	assign out_alpha = res.pix.alpha;

	`LDPM_ASSERT_IMP(a_no_res_overflow, bstat.res_push, bstat.res_cnt != 2'd2)
	`LDPM_ASSERT_IMP(a_take_only_on_adv, take, bstat.adv)
	`LDPM_ASSERT_NXT(a_size_write, wr && (idx == REG_SIZE), size_q == $past(pwdata[SIZE_W-1:0]))

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the lens distortion point map core.
`timescale 1ns / 1ps

module tb_top;
	import ldpm_pkg::*;

	typedef struct {
		logic [SRC_W-1:0]   sx;
		logic [SRC_W-1:0]   sy;
		logic [COLOR_W-1:0] r, g, b, a;
	} pixel_req_t;

	typedef struct {
		logic [DEST_W-1:0]  dx;
		logic [DEST_W-1:0]  dy;
		logic [COLOR_W-1:0] r, g, b, a;
	} mapped_pixel_t;

	localparam longint ONE_FX = longint'(1) <<< FRAC_BITS;
	localparam int STALL_LIMIT = 5000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 80;

	logic clk, arst_n;
	logic push, full, empty, pop;
	logic [SRC_W-1:0] src_x, src_y;
	logic [COLOR_W-1:0] in_red, in_green, in_blue, in_alpha;
	logic [DEST_W-1:0] dest_x, dest_y;
	logic [COLOR_W-1:0] out_red, out_green, out_blue, out_alpha;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [REG_W-1:0] pwdata, prdata;

	pixel_req_t pending_pixels[$];
	mapped_pixel_t expected_pixels[$];
	logic signed [REG_W-1:0] coef_regs[8];
	logic [SIZE_W-1:0] size_reg;
	bit gap_en;
	bit rx_hold_arm;
	bit rx_hold_done;
	int rx_hold_cnt;
	int errors;
	int quiet_cycles;

	lens_distortion_point_map_core uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.src_x(src_x), .src_y(src_y), .in_red(in_red), .in_green(in_green),
		.in_blue(in_blue), .in_alpha(in_alpha), .empty(empty), .pop(pop),
		.dest_x(dest_x), .dest_y(dest_y), .out_red(out_red), .out_green(out_green),
		.out_blue(out_blue), .out_alpha(out_alpha), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic longint clip32(input longint v);
		if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
		if (v < -64'sh8000_0000) return -64'sh8000_0000;
		return v;
	endfunction

	function automatic longint fx_mul(input longint a, input longint b);
		longint p;
		p = a * b;
		return clip32(p >>> FRAC_BITS);
	endfunction

	function automatic longint dim_of(input logic [12:0] d);
		if (d == 0) return 1;
		if (d > MAX_DIM) return MAX_DIM;
		return longint'(d);
	endfunction

	// Maps one source pixel; returns 0 when the point leaves the destination grid.
	function automatic bit distort_point(input pixel_req_t q, output mapped_pixel_t m);
		longint w, h, xn, yn, xp, yp, xx, yy, xy, r2, r4, r6, tx, ty, rc, xc, yc, dx, dy;
		longint k1, k2, k3, p1, p2;
		w = dim_of(size_reg[12:0]);
		h = dim_of(size_reg[25:13]);
		k1 = coef_regs[REG_K1]; k2 = coef_regs[REG_K2]; k3 = coef_regs[REG_K3];
		p1 = coef_regs[REG_P1]; p2 = coef_regs[REG_P2];
		xn = clip32((longint'(q.sx) <<< FRAC_BITS) / w);
		yn = clip32((longint'(q.sy) <<< FRAC_BITS) / h);
		xp = clip32(xn - longint'(coef_regs[REG_CX]));
		yp = clip32(yn - longint'(coef_regs[REG_CY]));
		xx = fx_mul(xp, xp);
		yy = fx_mul(yp, yp);
		xy = fx_mul(xp, yp);
		r2 = clip32(xx + yy);
		r4 = fx_mul(r2, r2);
		r6 = fx_mul(r4, r2);
		tx = clip32(clip32(2 * fx_mul(p1, xy)) + fx_mul(p2, clip32(r2 + 2 * xx)));
		ty = clip32(fx_mul(p1, clip32(r2 + 2 * yy)) + clip32(2 * fx_mul(p2, xy)));
		rc = clip32(ONE_FX + fx_mul(r2, k1) + fx_mul(r4, k2) + fx_mul(r6, k3));
		xc = clip32(fx_mul(xp, rc) + tx);
		yc = clip32(fx_mul(yp, rc) + ty);
		if (xc < -ONE_FX || yc < -ONE_FX) return 0;
		dx = ((xc + ONE_FX) * w) >>> FRAC_BITS;
		dy = ((yc + ONE_FX) * h) >>> FRAC_BITS;
		if (dx >= 2 * w || dy >= 2 * h) return 0;
		m.dx = dx[DEST_W-1:0];
		m.dy = dy[DEST_W-1:0];
		m.r = q.r; m.g = q.g; m.b = q.b; m.a = q.a;
		return 1;
	endfunction

	// Request driver: keeps the current request stable while the block is full.
	always @(posedge clk or negedge arst_n) begin
		pixel_req_t q;
		mapped_pixel_t m;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				q.sx = src_x; q.sy = src_y;
				q.r = in_red; q.g = in_green; q.b = in_blue; q.a = in_alpha;
				if (distort_point(q, m)) expected_pixels.push_back(m);
			end
			if (!(push && full)) begin
				if (pending_pixels.size() > 0 && !(gap_en && $urandom_range(99) < 19)) begin
					q = pending_pixels.pop_front();
					src_x <= q.sx; src_y <= q.sy;
					in_red <= q.r; in_green <= q.g; in_blue <= q.b; in_alpha <= q.a;
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure and one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		mapped_pixel_t e;
		if (!arst_n) begin
			pop <= 1'b0;
			rx_hold_done <= 1'b0;
			rx_hold_cnt <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_pixels.size() == 0) begin
					report($sformatf("unexpected result at (%0d,%0d)", dest_x, dest_y));
				end else begin
					e = expected_pixels.pop_front();
					if (dest_x !== e.dx) report($sformatf("dest_x %0d, want %0d", dest_x, e.dx));
					if (dest_y !== e.dy) report($sformatf("dest_y %0d, want %0d", dest_y, e.dy));
					if (out_red !== e.r) report($sformatf("out_red %0d, want %0d", out_red, e.r));
					if (out_green !== e.g)
						report($sformatf("out_green %0d, want %0d", out_green, e.g));
					if (out_blue !== e.b) report($sformatf("out_blue %0d, want %0d", out_blue, e.b));
					if (out_alpha !== e.a)
						report($sformatf("out_alpha %0d, want %0d", out_alpha, e.a));
				end
			end
			if (rx_hold_arm && !rx_hold_done) begin
				pop <= 1'b0;
				rx_hold_cnt <= rx_hold_cnt + 1;
				if (rx_hold_cnt == RX_HOLD_CYCLES) rx_hold_done <= 1'b1;
			end else begin
				pop <= !(gap_en && $urandom_range(99) < 19);
			end
		end
	end

	// Watchdog on cycles in which nothing is accepted.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'(4 * int'(idx));
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_SIZE) size_reg = val[SIZE_W-1:0];
		else coef_regs[idx] = $signed(val);
	endtask

	task automatic add_pixel(input int sx, input int sy);
		pixel_req_t q;
		q.sx = sx; q.sy = sy;
		q.r = $urandom; q.g = $urandom; q.b = $urandom; q.a = $urandom;
		pending_pixels.push_back(q);
	endtask

	task automatic drain_phase();
		while (pending_pixels.size() > 0 || push || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [REG_W-1:0] pick_coef();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return REG_W'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
		endcase
	endfunction

	function automatic logic [12:0] pick_dim();
		case ($urandom_range(9))
			0: return 13'd0;
			1: return 13'd8191;
			2: return 13'd4096;
			3: return 13'(4097 + $urandom_range(4000));
			default: return 13'($urandom_range(1, 64));
		endcase
	endfunction

	initial begin
		pixel_req_t q;
		int w, h;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		src_x = '0; src_y = '0;
		in_red = '0; in_green = '0; in_blue = '0; in_alpha = '0;
		gap_en = 1'b0;
		rx_hold_arm = 1'b0;
		errors = 0;
		quiet_cycles = 0;
		for (int i = 0; i < 7; i++) coef_regs[i] = '0;
		size_reg = SIZE_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: one-pixel image, so most sources lie outside it.
		add_pixel(0, 0);
		add_pixel(4095, 4095);
		add_pixel(0, 4095);
		add_pixel(4095, 0);
		add_pixel(1, 1);
		q.sx = 0; q.sy = 0; q.r = 8'hFF; q.g = 8'hFF; q.b = 8'hFF; q.a = 8'hFF;
		pending_pixels.push_back(q);
		q.r = 8'h00; q.g = 8'h00; q.b = 8'h00; q.a = 8'h00;
		pending_pixels.push_back(q);
		drain_phase();

		// Mild barrel distortion on a 640 by 480 image, with a long receiver hold-off.
		write_reg(REG_K1, 32'hFFF0_0000);
		write_reg(REG_K2, 32'h0008_0000);
		write_reg(REG_K3, 32'h0000_0000);
		write_reg(REG_P1, 32'h0001_0000);
		write_reg(REG_P2, 32'hFFFF_0000);
		write_reg(REG_CX, 32'h0080_0000);
		write_reg(REG_CY, 32'h0080_0000);
		write_reg(REG_SIZE, SIZE_W'({13'd480, 13'd640}));
		rx_hold_arm = 1'b1;
		for (int i = 0; i < 100; i++) add_pixel($urandom_range(639), $urandom_range(479));
		add_pixel(639, 479);
		add_pixel(0, 479);
		drain_phase();

		// Saturating coefficients, zero size fields and centers at the extremes; then all-ones size fields and zero centers.
		write_reg(REG_K1, 32'h7FFF_FFFF);
		write_reg(REG_K2, 32'h8000_0000);
		write_reg(REG_K3, 32'h7FFF_FFFF);
		write_reg(REG_P1, 32'h8000_0000);
		write_reg(REG_P2, 32'h7FFF_FFFF);
		write_reg(REG_CX, 32'h8000_0000);
		write_reg(REG_CY, 32'h7FFF_FFFF);
		write_reg(REG_SIZE, '0);
		add_pixel(0, 0);
		add_pixel(4095, 4095);
		add_pixel(2048, 1);
		drain_phase();
		write_reg(REG_SIZE, '1);
		write_reg(REG_CX, 32'h0000_0000);
		write_reg(REG_CY, 32'h0000_0000);
		add_pixel(4095, 4095);
		add_pixel(0, 0);
		add_pixel(2048, 2048);
		drain_phase();

		gap_en = 1'b1;
		for (int ph = 0; ph < 9; ph++) begin
			if (ph == 4) gap_en = 1'b0;
			if (ph == 6) gap_en = 1'b1;
			write_reg(REG_K1, pick_coef());
			write_reg(REG_K2, pick_coef());
			write_reg(REG_K3, pick_coef());
			write_reg(REG_P1, pick_coef());
			write_reg(REG_P2, pick_coef());
			write_reg(REG_CX, ($urandom_range(3) == 0) ? pick_coef()
				: REG_W'((1 << 23) + int'($urandom_range(0, 1 << 21)) - (1 << 20)));
			write_reg(REG_CY, ($urandom_range(3) == 0) ? pick_coef()
				: REG_W'((1 << 23) + int'($urandom_range(0, 1 << 21)) - (1 << 20)));
			write_reg(REG_SIZE, SIZE_W'({pick_dim(), pick_dim()}));
			w = int'(dim_of(size_reg[12:0]));
			h = int'(dim_of(size_reg[25:13]));
			for (int i = 0; i < 90; i++) begin
				if ($urandom_range(9) < 8)
					add_pixel($urandom_range(w > 4096 ? 4095 : w - 1),
						$urandom_range(h > 4096 ? 4095 : h - 1));
				else
					add_pixel($urandom_range(4095), $urandom_range(4095));
			end
			drain_phase();
		end

		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

### files.f
+incdir+design
design/ldpm_pkg.sv
design/ldpm_front.sv
design/ldpm_div.sv
design/ldpm_back.sv
design/lens_distortion_point_map_core.sv
tb/sv/tb_top.sv
